### rtl/core/stereo_multitap_feedback_delay_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo multi-tap feedback delay
// Concurrent checks clocked by clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEREO_MULTITAP_FEEDBACK_DELAY_ASSERT_SVH
`define STEREO_MULTITAP_FEEDBACK_DELAY_ASSERT_SVH

`ifndef SYNTHESIS
`define SMFD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SMFD_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SMFD_ASSERT(name, prop, msg)
`define SMFD_NEVER(name, expr, msg)
`endif

`endif

### rtl/core/smfd_pkg.sv
// ----------------------------------------------------------------------------
// Stereo multi-tap feedback delay package
// Widths, register indexes, state types, payload structs and helpers.
// ----------------------------------------------------------------------------
package smfd_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 12;
    localparam int MIX_GAIN_W = 16;
    localparam int BASE_W     = 16;
    localparam int TAPS       = 5;
    localparam int TAP_W      = $clog2(TAPS);
    localparam int ADDR_W     = 16;
    localparam int MAX_DELAY  = 1 << ADDR_W;
    localparam int LINE_DEPTH = TAPS * MAX_DELAY;
    localparam int CFG_W      = TAPS * GAIN_W;
    localparam int IDX_W      = 3;
    localparam int FB_SHIFT   = 11;
    localparam int MIX_SHIFT  = 15;
    localparam int WSUM_W     = SAMPLE_W + 4;
    localparam int DRY_W      = SAMPLE_W + 2;
    localparam int MUL_A_W    = WSUM_W;
    localparam int MUL_B_W    = MIX_GAIN_W + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int SUM_W      = 32;
    localparam int DLY_W      = BASE_W + 3;

    localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (SAMPLE_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    typedef enum logic [IDX_W-1:0] {
        REG_DRY_GAIN,
        REG_MASTER_WET_GAIN,
        REG_BASE_DELAY,
        REG_LEFT_WET_GAINS,
        REG_RIGHT_WET_GAINS,
        REG_LEFT_FEEDBACK_GAINS,
        REG_RIGHT_FEEDBACK_GAINS
    } cfg_index_t;

    typedef enum logic [3:0] {
        L_IDLE,
        L_FB,
        L_LINE,
        L_READ,
        L_ACC,
        L_DRY,
        L_WET,
        L_FIN,
        L_DONE
    } lane_state_t;

    typedef enum logic {
        T_IDLE,
        T_RUN
    } top_state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } result_t;

    typedef struct packed {
        logic              start;
        logic              ack;
        logic [ADDR_W-1:0] wp;
        logic              wrapped;
    } lane_ctrl_t;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[SAMPLE_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[SAMPLE_W-1:0];
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

    // Tap delays are fixed fractions of the beat length, clipped to the line size.
    function automatic logic [ADDR_W-1:0] tap_delay(input logic [BASE_W-1:0] base,
                                                    input logic [TAP_W-1:0] tap);
        logic [DLY_W-1:0] b;
        logic [DLY_W-1:0] d;
        b = DLY_W'(base);
        case (tap)
            TAP_W'(2): d = (b + (b << 1)) >> 2;
            TAP_W'(3): d = b >> 1;
            TAP_W'(4): d = (b + (b << 2)) >> 2;
            default:   d = b;
        endcase
        if (d > DLY_W'(MAX_DELAY - 1))
            return ADDR_W'(MAX_DELAY - 1);
        return d[ADDR_W-1:0];
    endfunction

endpackage

### rtl/core/smfd_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/smfd_lane.sv
// ----------------------------------------------------------------------------
// Channel lane
// Five feedback delay lines of one channel, worked tap by tap through one
// shared multiplier, followed by the dry and master wet mix.
// ----------------------------------------------------------------------------
module smfd_lane (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  smfd_pkg::lane_ctrl_t                   ctrl,
    input  logic signed [smfd_pkg::SAMPLE_W-1:0]   x,
    input  logic [smfd_pkg::BASE_W-1:0]            base_delay,
    input  logic [smfd_pkg::MIX_GAIN_W-1:0]        dry_gain,
    input  logic [smfd_pkg::MIX_GAIN_W-1:0]        master_wet_gain,
    input  logic [smfd_pkg::CFG_W-1:0]             wet_gains,
    input  logic [smfd_pkg::CFG_W-1:0]             feedback_gains,
    output logic                                   done,
    output logic signed [smfd_pkg::SAMPLE_W-1:0]   y
);

    smfd_pkg::lane_state_t state_reg, state_next;

    logic [smfd_pkg::TAP_W-1:0]                tap_reg;
    logic signed [smfd_pkg::SAMPLE_W-1:0]      x_reg;
    logic signed [smfd_pkg::PROD_W-1:0]        prod_reg;
    logic signed [smfd_pkg::WSUM_W-1:0]        wsum_reg;
    logic signed [smfd_pkg::DRY_W-1:0]         dry_reg;
    logic signed [smfd_pkg::SAMPLE_W-1:0]      line_in_reg;
    logic                                      zero_dly_reg;
    logic                                      rd_ok_reg;
    logic signed [smfd_pkg::SAMPLE_W-1:0]      prev_reg [smfd_pkg::TAPS];
    logic signed [smfd_pkg::SAMPLE_W-1:0]      y_reg;

    logic signed [smfd_pkg::MUL_A_W-1:0]       mul_a;
    logic signed [smfd_pkg::MUL_B_W-1:0]       mul_b;
    logic signed [smfd_pkg::PROD_W-1:0]        prod_shift_fb;
    logic signed [smfd_pkg::PROD_W-1:0]        prod_shift_mix;
    logic signed [smfd_pkg::SAMPLE_W-1:0]      line_in;
    logic signed [smfd_pkg::SAMPLE_W-1:0]      tap_val;
    logic [smfd_pkg::GAIN_W-1:0]               fb_k;
    logic [smfd_pkg::GAIN_W-1:0]               wg_k;
    logic [smfd_pkg::ADDR_W-1:0]               dly;
    logic [smfd_pkg::ADDR_W-1:0]               rd_pos;
    logic [smfd_pkg::SAMPLE_W-1:0]             ram_rdata;
    logic                                      ram_we;
    logic signed [smfd_pkg::SUM_W-1:0]         mix_sum;

    assign fb_k = feedback_gains[tap_reg * smfd_pkg::GAIN_W +: smfd_pkg::GAIN_W];
    assign wg_k = wet_gains[tap_reg * smfd_pkg::GAIN_W +: smfd_pkg::GAIN_W];
    assign dly  = smfd_pkg::tap_delay(base_delay, tap_reg);
    // The line length is a power of two, so the read position wraps by itself.
    assign rd_pos = ctrl.wp - dly;

    assign prod_shift_fb  = prod_reg >>> smfd_pkg::FB_SHIFT;
    assign prod_shift_mix = prod_reg >>> smfd_pkg::MIX_SHIFT;

    assign line_in = smfd_pkg::sat_sample(smfd_pkg::SUM_W'(x_reg)
                                          + smfd_pkg::SUM_W'(prod_shift_fb));

    // A zero delay returns the sample just written; entries beyond the fill
    // point have never been written and read as silence.
    always_comb
    begin
        if (zero_dly_reg)
            tap_val = line_in_reg;
        else if (rd_ok_reg)
            tap_val = ram_rdata;
        else
            tap_val = '0;
    end

    assign mix_sum = smfd_pkg::SUM_W'(dry_reg) + smfd_pkg::SUM_W'(prod_shift_mix);

    assign ram_we = (state_reg == smfd_pkg::L_LINE);

    smfd_ram #(
        .WIDTH (smfd_pkg::SAMPLE_W),
        .DEPTH (smfd_pkg::LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({tap_reg, ctrl.wp}),
        .wdata (line_in),
        .raddr ({tap_reg, rd_pos}),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smfd_pkg::L_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            smfd_pkg::L_IDLE:
            begin
                if (ctrl.start)
                    state_next = smfd_pkg::L_FB;
            end
            smfd_pkg::L_FB:
            begin
                mul_a      = smfd_pkg::MUL_A_W'(prev_reg[tap_reg]);
                mul_b      = smfd_pkg::MUL_B_W'(fb_k);
                state_next = smfd_pkg::L_LINE;
            end
            smfd_pkg::L_LINE:
            begin
                state_next = smfd_pkg::L_READ;
            end
            smfd_pkg::L_READ:
            begin
                mul_a      = smfd_pkg::MUL_A_W'(tap_val);
                mul_b      = smfd_pkg::MUL_B_W'(wg_k);
                state_next = smfd_pkg::L_ACC;
            end
            smfd_pkg::L_ACC:
            begin
                if (tap_reg == smfd_pkg::TAP_W'(smfd_pkg::TAPS - 1))
                    state_next = smfd_pkg::L_DRY;
                else
                    state_next = smfd_pkg::L_FB;
            end
            smfd_pkg::L_DRY:
            begin
                mul_a      = smfd_pkg::MUL_A_W'(x_reg);
                mul_b      = smfd_pkg::MUL_B_W'(dry_gain);
                state_next = smfd_pkg::L_WET;
            end
            smfd_pkg::L_WET:
            begin
                mul_a      = wsum_reg;
                mul_b      = smfd_pkg::MUL_B_W'(master_wet_gain);
                state_next = smfd_pkg::L_FIN;
            end
            smfd_pkg::L_FIN:
            begin
                state_next = smfd_pkg::L_DONE;
            end
            smfd_pkg::L_DONE:
            begin
                if (ctrl.ack)
                    state_next = smfd_pkg::L_IDLE;
            end
            default:
            begin
                state_next = smfd_pkg::L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
            for (int i = 0; i < smfd_pkg::TAPS; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == smfd_pkg::L_IDLE && ctrl.start)
                tap_reg <= '0;
            else if (state_reg == smfd_pkg::L_ACC
                     && tap_reg != smfd_pkg::TAP_W'(smfd_pkg::TAPS - 1))
                tap_reg <= tap_reg + smfd_pkg::TAP_W'(1);
            if (state_reg == smfd_pkg::L_READ)
                prev_reg[tap_reg] <= tap_val;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (state_reg == smfd_pkg::L_IDLE && ctrl.start)
        begin
            x_reg    <= x;
            wsum_reg <= '0;
        end
        if (state_reg == smfd_pkg::L_LINE)
        begin
            line_in_reg  <= line_in;
            zero_dly_reg <= (dly == '0);
            rd_ok_reg    <= ctrl.wrapped || (rd_pos <= ctrl.wp);
        end
        if (state_reg == smfd_pkg::L_ACC)
            wsum_reg <= wsum_reg + smfd_pkg::WSUM_W'(prod_shift_fb);
        if (state_reg == smfd_pkg::L_WET)
            dry_reg <= smfd_pkg::DRY_W'(prod_shift_mix);
        if (state_reg == smfd_pkg::L_FIN)
            y_reg <= smfd_pkg::sat_sample(mix_sum);
    end

    assign done = (state_reg == smfd_pkg::L_DONE);
    assign y    = y_reg;

endmodule

### rtl/core/stereo_multitap_feedback_delay.sv
// ----------------------------------------------------------------------------
// Stereo multi-tap feedback delay
// Two channel lanes side by side, configuration registers, the shared line
// position and the output register that merges both lanes into one result.
// ----------------------------------------------------------------------------
// Usage:
// The sample channel carries one stereo pair per transfer (sample_valid,
// sample_stall, sample); the result channel returns one processed pair per
// accepted sample (result_valid, result_stall, result). Both lanes run in
// lockstep, each with one multiplier used twice per tap, in the FB and READ
// states, and twice more for the mix; the block takes a new sample only after
// the lanes have finished the previous one and handed its result over.
// The result sits in an output register; a new sample is taken while it
// waits. If the receiver stalls long enough that the next result is ready
// while the previous one is still held, the lanes keep their result and the
// sample side stays stalled until the output register frees up.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and belong in idle periods. Reset restores the register defaults, empties
// all delay lines (tracked by a fill flag, no clearing pass) and clears the
// feedback history.
// ----------------------------------------------------------------------------
`include "stereo_multitap_feedback_delay_assert.svh"

module stereo_multitap_feedback_delay (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  smfd_pkg::sample_t               sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output smfd_pkg::result_t               result,
    input  logic                            cfg_write,
    input  logic [smfd_pkg::IDX_W-1:0]      cfg_index,
    input  logic [smfd_pkg::CFG_W-1:0]      cfg_data
);

    smfd_pkg::top_state_t state_reg, state_next;

    logic [smfd_pkg::MIX_GAIN_W-1:0] dry_gain_reg;
    logic [smfd_pkg::MIX_GAIN_W-1:0] master_wet_gain_reg;
    logic [smfd_pkg::BASE_W-1:0]     base_delay_reg;
    logic [smfd_pkg::CFG_W-1:0]      left_wet_gains_reg;
    logic [smfd_pkg::CFG_W-1:0]      right_wet_gains_reg;
    logic [smfd_pkg::CFG_W-1:0]      left_feedback_gains_reg;
    logic [smfd_pkg::CFG_W-1:0]      right_feedback_gains_reg;

    logic [smfd_pkg::ADDR_W-1:0]     wp_reg;
    logic                            wrapped_reg;
    logic                            result_valid_reg;
    smfd_pkg::result_t               result_reg;

    smfd_pkg::lane_ctrl_t            lane_ctrl;
    logic                            left_done;
    logic                            right_done;
    logic signed [smfd_pkg::SAMPLE_W-1:0] left_y;
    logic signed [smfd_pkg::SAMPLE_W-1:0] right_y;

    logic                            sample_xfer;
    logic                            slot_free;
    logic                            load;

    assign sample_xfer = sample_valid && !sample_stall;
    assign slot_free   = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_gain_reg             <= smfd_pkg::MIX_GAIN_W'(16384);
            master_wet_gain_reg      <= smfd_pkg::MIX_GAIN_W'(16384);
            base_delay_reg           <= smfd_pkg::BASE_W'(24000);
            left_wet_gains_reg       <= '0;
            right_wet_gains_reg      <= '0;
            left_feedback_gains_reg  <= '0;
            right_feedback_gains_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (smfd_pkg::cfg_index_t'(cfg_index))
                smfd_pkg::REG_DRY_GAIN:
                    dry_gain_reg <= cfg_data[smfd_pkg::MIX_GAIN_W-1:0];
                smfd_pkg::REG_MASTER_WET_GAIN:
                    master_wet_gain_reg <= cfg_data[smfd_pkg::MIX_GAIN_W-1:0];
                smfd_pkg::REG_BASE_DELAY:
                    base_delay_reg <= cfg_data[smfd_pkg::BASE_W-1:0];
                smfd_pkg::REG_LEFT_WET_GAINS:
                    left_wet_gains_reg <= cfg_data;
                smfd_pkg::REG_RIGHT_WET_GAINS:
                    right_wet_gains_reg <= cfg_data;
                smfd_pkg::REG_LEFT_FEEDBACK_GAINS:
                    left_feedback_gains_reg <= cfg_data;
                smfd_pkg::REG_RIGHT_FEEDBACK_GAINS:
                    right_feedback_gains_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smfd_pkg::T_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sample_stall    = 1'b1;
        load            = 1'b0;
        lane_ctrl.start = 1'b0;
        unique case (state_reg)
            smfd_pkg::T_IDLE:
            begin
                sample_stall    = 1'b0;
                lane_ctrl.start = sample_valid;
                if (sample_valid)
                    state_next = smfd_pkg::T_RUN;
            end
            smfd_pkg::T_RUN:
            begin
                if (left_done && slot_free)
                begin
                    load       = 1'b1;
                    state_next = smfd_pkg::T_IDLE;
                end
            end
            default:
            begin
                state_next = smfd_pkg::T_IDLE;
            end
        endcase
        lane_ctrl.ack     = load;
        lane_ctrl.wp      = wp_reg;
        lane_ctrl.wrapped = wrapped_reg;
    end

    smfd_lane u_left_lane (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (lane_ctrl),
        .x               (sample.left_in),
        .base_delay      (base_delay_reg),
        .dry_gain        (dry_gain_reg),
        .master_wet_gain (master_wet_gain_reg),
        .wet_gains       (left_wet_gains_reg),
        .feedback_gains  (left_feedback_gains_reg),
        .done            (left_done),
        .y               (left_y)
    );

    smfd_lane u_right_lane (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (lane_ctrl),
        .x               (sample.right_in),
        .base_delay      (base_delay_reg),
        .dry_gain        (dry_gain_reg),
        .master_wet_gain (master_wet_gain_reg),
        .wet_gains       (right_wet_gains_reg),
        .feedback_gains  (right_feedback_gains_reg),
        .done            (right_done),
        .y               (right_y)
    );

    // The write position moves once per finished sample; the fill flag marks
    // the first wrap, after which every line entry holds written data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg           <= '0;
            wrapped_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                wp_reg <= wp_reg + smfd_pkg::ADDR_W'(1);
                if (wp_reg == smfd_pkg::ADDR_W'(smfd_pkg::MAX_DELAY - 1))
                    wrapped_reg <= 1'b1;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.left_out  <= left_y;
            result_reg.right_out <= right_y;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `SMFD_ASSERT(a_lanes_lockstep, left_done == right_done, "lanes out of step")
    `SMFD_ASSERT(a_wp_advance, load |=> wp_reg == $past(wp_reg) + smfd_pkg::ADDR_W'(1), "write position did not advance")
    `SMFD_ASSERT(a_fill_sticky, wrapped_reg |=> wrapped_reg, "fill flag dropped")
    `SMFD_NEVER(a_load_over_held, load && result_valid_reg && result_stall, "held result overwritten")
    `SMFD_ASSERT(a_no_instant_result, sample_xfer |=> !load, "result loaded right after transfer")

endmodule

### tb/stereo_multitap_feedback_delay_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo predictor and result checker
// Watches the configuration port and the sample and result channels, keeps its own copy
// of the delay lines and feedback history, predicts each output pair and
// compares every result transfer with the oldest predicted pair.
// ----------------------------------------------------------------------------
module stereo_multitap_feedback_delay_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    input  logic                         sample_stall,
    input  smfd_pkg::sample_t            sample,
    input  logic                         result_valid,
    input  logic                         result_stall,
    input  smfd_pkg::result_t            result,
    input  logic                         cfg_write,
    input  logic [smfd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [smfd_pkg::CFG_W-1:0]   cfg_data,
    output int                           pending,
    output int                           failures
);

    logic [smfd_pkg::MIX_GAIN_W-1:0] dry_gain;
    logic [smfd_pkg::MIX_GAIN_W-1:0] master_gain;
    logic [smfd_pkg::BASE_W-1:0]     beat_len;
    logic [smfd_pkg::CFG_W-1:0]      wet_gains [2];
    logic [smfd_pkg::CFG_W-1:0]      fb_gains [2];

    int                 echo_mem [2][smfd_pkg::LINE_DEPTH];
    int                 last_tap [2][smfd_pkg::TAPS];
    int                 write_pos;
    smfd_pkg::result_t  predicted_pairs [$];

    assign pending = predicted_pairs.size();

    function automatic longint clip24(longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    function automatic int echo_delay(int k);
        int b;
        int d;
        b = int'(beat_len);
        case (k)
            2: d = (3 * b) >> 2;
            3: d = b >> 1;
            4: d = (5 * b) >> 2;
            default: d = b;
        endcase
        if (d > smfd_pkg::MAX_DELAY - 1)
            d = smfd_pkg::MAX_DELAY - 1;
        return d;
    endfunction

    // Runs both channels for one pair and advances the shared line position.
    function smfd_pkg::result_t predict_pair(smfd_pkg::sample_t s);
        longint             x;
        longint             fb;
        longint             wg;
        longint             line_in;
        longint             wet_sum;
        longint             mix;
        int                 d;
        int                 rd;
        int                 tap;
        smfd_pkg::result_t  r;
        for (int c = 0; c < 2; c++)
        begin
            x = (c == 0) ? longint'(s.left_in) : longint'(s.right_in);
            wet_sum = 0;
            for (int k = 0; k < smfd_pkg::TAPS; k++)
            begin
                fb = longint'(fb_gains[c][12*k +: 12]);
                wg = longint'(wet_gains[c][12*k +: 12]);
                line_in = clip24(x + ((longint'(last_tap[c][k]) * fb) >>> smfd_pkg::FB_SHIFT));
                d = echo_delay(k);
                rd = (write_pos + smfd_pkg::MAX_DELAY - d) % smfd_pkg::MAX_DELAY;
                echo_mem[c][k*smfd_pkg::MAX_DELAY + write_pos] = int'(line_in);
                tap = echo_mem[c][k*smfd_pkg::MAX_DELAY + rd];
                last_tap[c][k] = tap;
                wet_sum += (longint'(tap) * wg) >>> smfd_pkg::FB_SHIFT;
            end
            mix = clip24(((x * longint'(dry_gain)) >>> smfd_pkg::MIX_SHIFT)
                         + ((wet_sum * longint'(master_gain)) >>> smfd_pkg::MIX_SHIFT));
            if (c == 0)
                r.left_out = mix[smfd_pkg::SAMPLE_W-1:0];
            else
                r.right_out = mix[smfd_pkg::SAMPLE_W-1:0];
        end
        write_pos = (write_pos + 1) % smfd_pkg::MAX_DELAY;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        smfd_pkg::result_t want;
        int                errs;
        errs = 0;
        if (!rst_n)
        begin
            dry_gain    <= 16'd16384;
            master_gain <= 16'd16384;
            beat_len    <= 16'd24000;
            for (int c = 0; c < 2; c++)
            begin
                wet_gains[c] <= '0;
                fb_gains[c]  <= '0;
                for (int k = 0; k < smfd_pkg::TAPS; k++)
                    last_tap[c][k] = 0;
                for (int i = 0; i < smfd_pkg::LINE_DEPTH; i++)
                    echo_mem[c][i] = 0;
            end
            write_pos = 0;
            predicted_pairs.delete();
            failures <= 0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
                predicted_pairs.push_back(predict_pair(sample));
            if (result_valid && !result_stall)
            begin
                if (predicted_pairs.size() == 0)
                begin
                    $error("result transfer with no sample outstanding");
                    errs++;
                end
                else
                begin
                    want = predicted_pairs.pop_front();
                    if (result.left_out !== want.left_out)
                    begin
                        $error("left_out expected %0d got %0d", want.left_out,
                               result.left_out);
                        errs++;
                    end
                    if (result.right_out !== want.right_out)
                    begin
                        $error("right_out expected %0d got %0d", want.right_out,
                               result.right_out);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                failures <= failures + errs;
            // Register writes land after this cycle's sample is predicted.
            if (cfg_write)
            begin
                case (cfg_index)
                    smfd_pkg::REG_DRY_GAIN:             dry_gain <= cfg_data[15:0];
                    smfd_pkg::REG_MASTER_WET_GAIN:      master_gain <= cfg_data[15:0];
                    smfd_pkg::REG_BASE_DELAY:           beat_len <= cfg_data[15:0];
                    smfd_pkg::REG_LEFT_WET_GAINS:       wet_gains[0] <= cfg_data;
                    smfd_pkg::REG_RIGHT_WET_GAINS:      wet_gains[1] <= cfg_data;
                    smfd_pkg::REG_LEFT_FEEDBACK_GAINS:  fb_gains[0] <= cfg_data;
                    smfd_pkg::REG_RIGHT_FEEDBACK_GAINS: fb_gains[1] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/stereo_multitap_feedback_delay_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo multi-tap feedback delay test
// Drives directed and random stereo pairs through several register settings
// with random gaps and stalls on both channels; the checker predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module stereo_multitap_feedback_delay_test;

    localparam logic [smfd_pkg::IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic signed [smfd_pkg::SAMPLE_W-1:0] PEAK_POS = 24'sh7FFFFF;
    localparam logic signed [smfd_pkg::SAMPLE_W-1:0] PEAK_NEG = 24'sh800000;

    logic                          clk;
    logic                          rst_n;
    logic                          sample_valid;
    logic                          sample_stall;
    smfd_pkg::sample_t             sample;
    logic                          result_valid;
    logic                          result_stall;
    smfd_pkg::result_t             result;
    logic                          cfg_write;
    logic [smfd_pkg::IDX_W-1:0]    cfg_index;
    logic [smfd_pkg::CFG_W-1:0]    cfg_data;
    int                            pending;
    int                            failures;
    int                            cycle_count = 0;
    bit                            calm;
    bit                            hold_request;
    bit                            hold_done;

    stereo_multitap_feedback_delay u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    stereo_multitap_feedback_delay_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .failures     (failures)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[stereo_multitap_feedback_delay] ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (calm || r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (hold_request && !hold_done)
            begin
                result_stall <= 1'b1;
                repeat (600) @(posedge clk);
                result_stall <= 1'b0;
                hold_done <= 1'b1;
            end
            else
                result_stall <= (pick_gap() != 0);
        end
    end

    task automatic send_pair(logic signed [smfd_pkg::SAMPLE_W-1:0] l,
                             logic signed [smfd_pkg::SAMPLE_W-1:0] r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample.left_in <= l;
        sample.right_in <= r;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    // Lets the block drain, then writes one register.
    task automatic write_reg(logic [smfd_pkg::IDX_W-1:0] idx,
                             logic [smfd_pkg::CFG_W-1:0] value);
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [smfd_pkg::CFG_W-1:0] random_gains();
        return smfd_pkg::CFG_W'({$urandom, $urandom});
    endfunction

    function automatic logic signed [smfd_pkg::SAMPLE_W-1:0] random_level();
        case ($urandom_range(0, 9))
            0: return PEAK_POS;
            1: return PEAK_NEG;
            2: return smfd_pkg::SAMPLE_W'($urandom_range(0, 200)) - 24'sd100;
            default: return smfd_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic random_settings();
        write_reg(smfd_pkg::REG_DRY_GAIN, smfd_pkg::CFG_W'($urandom_range(0, 32768)));
        write_reg(smfd_pkg::REG_MASTER_WET_GAIN, smfd_pkg::CFG_W'($urandom_range(0, 32768)));
        if ($urandom_range(0, 5) == 0)
            write_reg(smfd_pkg::REG_BASE_DELAY, smfd_pkg::CFG_W'($urandom_range(0, 52428)));
        else
            write_reg(smfd_pkg::REG_BASE_DELAY, smfd_pkg::CFG_W'($urandom_range(0, 24)));
        write_reg(smfd_pkg::REG_LEFT_WET_GAINS, random_gains());
        write_reg(smfd_pkg::REG_RIGHT_WET_GAINS, random_gains());
        write_reg(smfd_pkg::REG_LEFT_FEEDBACK_GAINS, random_gains());
        write_reg(smfd_pkg::REG_RIGHT_FEEDBACK_GAINS, random_gains());
    endtask

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 1'b0;
        hold_request = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: dry only at half gain.
        send_pair(PEAK_POS, PEAK_NEG);
        send_pair(PEAK_NEG, PEAK_POS);
        send_pair(24'sd1, -24'sd1);

        // Zero delay returns the sample just written; full gains saturate.
        write_reg(smfd_pkg::REG_BASE_DELAY, '0);
        write_reg(smfd_pkg::REG_DRY_GAIN, smfd_pkg::CFG_W'(32768));
        write_reg(smfd_pkg::REG_MASTER_WET_GAIN, smfd_pkg::CFG_W'(32768));
        write_reg(smfd_pkg::REG_LEFT_WET_GAINS, '1);
        write_reg(smfd_pkg::REG_RIGHT_WET_GAINS, {5{12'h800}});
        write_reg(smfd_pkg::REG_LEFT_FEEDBACK_GAINS, '1);
        write_reg(smfd_pkg::REG_RIGHT_FEEDBACK_GAINS, {5{12'h400}});
        send_pair(PEAK_POS, PEAK_NEG);
        send_pair(PEAK_NEG, PEAK_POS);
        send_pair('0, '0);
        send_pair(24'sh555555, 24'shAAAAAA);

        // Short delays and a write to an unmapped index that must be ignored.
        write_reg(smfd_pkg::REG_BASE_DELAY, smfd_pkg::CFG_W'(3));
        write_reg(REG_UNMAPPED, '1);
        for (int i = 0; i < 8; i++)
            send_pair(random_level(), random_level());

        // A beat of 52428 puts the slowest tap at exactly the longest delay the line holds.
        write_reg(smfd_pkg::REG_BASE_DELAY, smfd_pkg::CFG_W'(52428));
        write_reg(smfd_pkg::REG_DRY_GAIN, '0);
        send_pair(PEAK_POS, PEAK_NEG);
        send_pair(24'shAAAAAA, 24'sh555555);

        for (int phase = 0; phase < 5; phase++)
        begin
            random_settings();
            calm = (phase == 2);
            for (int i = 0; i < 106; i++)
            begin
                if (phase == 1 && i == 10)
                    hold_request <= 1'b1;
                // Sender pauses here until the block has drained.
                if (phase == 3 && i == 50)
                begin
                    sample_valid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0)
                        @(posedge clk);
                end
                send_pair(random_level(), random_level());
            end
        end
        calm = 1'b0;

        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (failures == 0)
            $display("[stereo_multitap_feedback_delay] OK");
        else
            $display("[stereo_multitap_feedback_delay] ERROR");
        $finish;
    end

endmodule
